[rtl/kds_pkg.sv]
// shared types, constants and a lookup function for the keypad and display scanner
package kds_pkg;

   localparam int SCAN_POSITIONS = 16;
   localparam int POS_W = 4;
   localparam int LINES_W = 5;
   localparam int COL_W = 3;
   localparam int CODE_W = 5;
   localparam int VALUE_W = 10;
   localparam int SEG_W = 16;
   localparam int DIGIT_COUNT = 3;
   localparam int DIGIT_IDX_W = 2;
   localparam int COUNT_W = 2;

   localparam logic [LINES_W-1:0] ALL_HIGH = 5'h1F;
   localparam logic [CODE_W-1:0] BLANK_CODE = 5'd16;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;
   localparam logic [COL_W-1:0] MOVE_LAST_COL = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_ARM = 2'd2;
   localparam logic [COUNT_W-1:0] COUNT_HELD = 2'd3;

   localparam int LINE_MOVE = 2;
   localparam int LINE_ENTER = 3;
   localparam int LINE_EXTRA = 4;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_SET  = 1'b1
   } op_type;

   typedef struct packed {
      logic                valid;
      logic [COL_W-1:0]    column;
      logic [LINES_W-1:0]  rows;
      logic                beep;
      logic                repeating;
   } key_report_type;

   function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] seg;
      case (code)
         5'd0: seg = 16'h3E7C;
         5'd1: seg = 16'h7FFE;
         5'd2: seg = 16'h3D7D;
         5'd3: seg = 16'h3DFC;
         5'd4: seg = 16'h7CFE;
         5'd5: seg = 16'hBCFC;
         5'd6: seg = 16'hBC7C;
         5'd7: seg = 16'h3FFE;
         5'd8: seg = 16'h3C7C;
         5'd9: seg = 16'h3CFC;
         5'd10: seg = 16'h3C7E;
         5'd11: seg = 16'hFC7C;
         5'd12: seg = 16'hBE7D;
         5'd13: seg = 16'h7D7C;
         5'd14: seg = 16'hBC7D;
         5'd15: seg = 16'hBC7F;
         default: seg = 16'hFFFF;
      endcase
      return seg;
   endfunction

endpackage

[rtl/kds_channels.sv]
// valid/ready channel interfaces for request and response beats
interface kds_req_if import kds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [0:0]          opcode;
   logic [LINES_W-1:0]  return_lines;
   logic [VALUE_W-1:0]  display_value;

   modport source(output valid, opcode, return_lines, display_value, input ready);
   modport sink(input valid, opcode, return_lines, display_value, output ready);
endinterface

interface kds_rsp_if import kds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    digit_select;
   logic [SEG_W-1:0]    segments;
   logic                key_valid;
   logic [COL_W-1:0]    key_column;
   logic [LINES_W-1:0]  key_rows;
   logic                beep;
   logic                repeating;

   modport source(output valid, digit_select, segments, key_valid, key_column, key_rows,
                  beep, repeating, input ready);
   modport sink(input valid, digit_select, segments, key_valid, key_column, key_rows,
                beep, repeating, output ready);
endinterface

[rtl/keypad_display_scanner.sv]
// Keypad and seven-segment display scanner. Each scan tick beat gives exactly one response
// beat with the scan position, its active-low segment pattern and any debounced key report;
// a set-value beat updates the three displayed digits and gives no response. Beats pass an
// input register and a result register; a tick loads the result register as it leaves
// the input register. One request is taken every cycle unless a waiting response stalls it.
// Scan positions run 0 to SCAN_POSITIONS-1 and wrap.
module keypad_display_scanner import kds_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   kds_req_if.sink   req_if,
   kds_rsp_if.source rsp_if
);

   logic                in_valid_ff, in_valid_in;
   op_type              in_op_ff;
   logic [LINES_W-1:0]  in_lines_ff;
   logic [VALUE_W-1:0]  in_value_ff;

   logic                out_valid_ff, out_valid_in;
   logic [POS_W-1:0]    out_pos_ff;
   logic [SEG_W-1:0]    out_seg_ff;
   key_report_type      out_key_ff;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CODE_W-1:0]   digit_ff [DIGIT_COUNT];
   logic [CODE_W-1:0]   digit_in [DIGIT_COUNT];

   logic                req_fire;
   logic                advance;
   logic                tick_adv;
   logic                set_adv;
   logic [CODE_W-1:0]   code;
   key_report_type      key_report;

   assign req_fire = req_if.valid && req_if.ready;
   assign advance = in_valid_ff && (in_op_ff == OP_SET || !out_valid_ff || rsp_if.ready);
   assign tick_adv = advance && in_op_ff == OP_TICK;
   assign set_adv = advance && in_op_ff == OP_SET;
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = tick_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
      pos_in = (pos_ff == POS_W'(SCAN_POSITIONS - 1)) ? '0 : pos_ff + 1'b1;
      code = (pos_ff < POS_W'(DIGIT_COUNT)) ? digit_ff[pos_ff[DIGIT_IDX_W-1:0]] : '0;
   end

   kds_digit_conv u_digit_conv (
      .value       (in_value_ff),
      .digit_codes (digit_in)
   );

   kds_key_debounce u_key_debounce (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick_adv),
      .column (pos_ff[COL_W-1:0]),
      .lines  (in_lines_ff),
      .report (key_report)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (tick_adv) begin
            pos_ff <= pos_in;
         end
         if (set_adv) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               digit_ff[i] <= digit_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff <= op_type'(req_if.opcode);
         in_lines_ff <= req_if.return_lines;
         in_value_ff <= req_if.display_value;
      end
      if (tick_adv) begin
         out_pos_ff <= pos_ff;
         out_seg_ff <= seg_lookup(code);
         out_key_ff <= key_report;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.digit_select = out_pos_ff;
   assign rsp_if.segments = out_seg_ff;
   assign rsp_if.key_valid = out_key_ff.valid;
   assign rsp_if.key_column = out_key_ff.column;
   assign rsp_if.key_rows = out_key_ff.rows;
   assign rsp_if.beep = out_key_ff.beep;
   assign rsp_if.repeating = out_key_ff.repeating;

   a_tick_gives_beat: assert property (@(posedge clock) disable iff (reset)
      tick_adv |=> out_valid_ff)
      else $error("tick beat did not load the result register");

   a_quiet_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.key_valid) |->
         (rsp_if.key_rows == '0 && !rsp_if.beep && !rsp_if.repeating && rsp_if.key_column == '0))
      else $error("key fields set without a key report");

   a_repeat_on_move_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.repeating) |-> (rsp_if.key_column <= MOVE_LAST_COL))
      else $error("auto-repeat reported outside the move columns");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (int'(rsp_if.digit_select) < SCAN_POSITIONS))
      else $error("scan position out of range");

endmodule

[rtl/kds_digit_conv.sv]
// splits a display value, saturated at 999, into three digit codes with leading-zero blanking
module kds_digit_conv import kds_pkg::*; (
   input  logic [VALUE_W-1:0] value,
   output logic [CODE_W-1:0]  digit_codes [DIGIT_COUNT]
);

   logic [VALUE_W-1:0] sat;
   logic [3:0]         hund;
   logic [3:0]         tens;
   logic [6:0]         rem_h;
   logic [3:0]         rem_t;

   always_comb begin
      sat = (value > VALUE_MAX) ? VALUE_MAX : value;
      hund = 4'd0;
      rem_h = sat[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (sat >= VALUE_W'(k * 100)) begin
            hund = 4'(k);
            rem_h = 7'(sat - VALUE_W'(k * 100));
         end
      end
      tens = 4'd0;
      rem_t = rem_h[3:0];
      for (int k = 1; k <= 9; k++) begin
         if (rem_h >= 7'(k * 10)) begin
            tens = 4'(k);
            rem_t = 4'(rem_h - 7'(k * 10));
         end
      end
      digit_codes[0] = (sat >= 10'd100) ? {1'b0, hund} : BLANK_CODE;
      digit_codes[1] = (sat >= 10'd10) ? {1'b0, tens} : BLANK_CODE;
      digit_codes[2] = {1'b0, rem_t};
   end

endmodule

[rtl/kds_key_debounce.sv]
// key return line debounce, press reporting and move key auto-repeat
module kds_key_debounce import kds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic [COL_W-1:0]    column,
   input  logic [LINES_W-1:0]  lines,
   output key_report_type      report
);

   logic [LINES_W-1:0] snap_ff, snap_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               armed_ff, armed_in;
   logic [COL_W-1:0]   pcol_ff, pcol_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= '0;
         count_ff <= '0;
         armed_ff <= 1'b0;
         pcol_ff <= '0;
      end else if (tick) begin
         snap_ff <= snap_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
         pcol_ff <= pcol_in;
      end
   end

   always_comb begin
      logic [LINES_W-1:0] pressed;
      logic               valid;
      logic               beep;
      logic               rep;
      snap_in = snap_ff;
      count_in = count_ff;
      armed_in = armed_ff;
      pcol_in = pcol_ff;
      valid = 1'b0;
      beep = 1'b0;
      rep = 1'b0;
      if (lines != ALL_HIGH) begin
         if (count_in == '0) begin
            snap_in = lines;
         end
         if (snap_in == lines) begin
            if (count_in != COUNT_HELD) begin
               count_in = count_in + 1'b1;
            end
            pcol_in = column;
            if (count_in == COUNT_ARM) begin
               armed_in = 1'b1;
            end
         end
      end
      pressed = ~snap_in;
      if (column == pcol_in) begin
         if (lines == ALL_HIGH) begin
            count_in = '0;
            armed_in = 1'b0;
         end
         if (count_in >= COUNT_ARM && armed_in) begin
            if (column <= MOVE_LAST_COL) begin
               if (pressed[LINE_MOVE]) begin
                  armed_in = 1'b1;
                  valid = 1'b1;
                  if (count_in == COUNT_ARM) begin
                     beep = 1'b1;
                  end else begin
                     rep = 1'b1;
                  end
                  count_in = COUNT_HELD;
               end
               if (pressed[LINE_ENTER] || (column == MOVE_LAST_COL && pressed[LINE_EXTRA])) begin
                  armed_in = 1'b0;
                  valid = 1'b1;
                  beep = 1'b1;
               end
            end else begin
               armed_in = 1'b0;
               valid = 1'b1;
               beep = 1'b1;
            end
         end
      end
      report.valid = valid;
      report.column = valid ? column : '0;
      report.rows = valid ? pressed : '0;
      report.beep = valid && beep;
      report.repeating = valid && rep;
   end

endmodule
